// ===== design/arsum_pkg.sv =====
// Shared constants for the alternating range sum block.
// Field widths, item operation codes and the default element count.
// No dependencies.
`timescale 1ns / 1ps

package arsum_pkg;

	localparam int unsigned IDX_W        = 11;
	localparam int unsigned VAL_W        = 32;
	localparam int unsigned SUM_W        = 64;
	localparam int unsigned MAX_ELEM_DEF = 1024;

	localparam logic OP_SET   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic [SUM_W-1:0] sum_t;

endpackage

// ===== design/alternating_range_sum_tree.sv =====
// A set reads the old element, then walks its update chain, at most log2(N)+1 tree nodes;
// a query walks the set bits of right_end, then those of left_end-1, one tree read each.
// One item at a time; the walk runs on the tree memory's single read port, a new item
// is taken once the previous walk ends. A finished result waits in the output register.
// Reset: asynchronous; the block then sweeps both memories to zero, one entry a cycle,
// and takes no item until the sweep is done.
`timescale 1ns / 1ps

module alternating_range_sum_tree
	import arsum_pkg::*;
#(
	parameter int unsigned MAX_ELEMENTS = MAX_ELEM_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic                    operation,
	input  logic [IDX_W-1:0]        index,
	input  logic signed [VAL_W-1:0] value,
	input  logic [IDX_W-1:0]        left_end,
	input  logic [IDX_W-1:0]        right_end,
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic signed [SUM_W-1:0] range_sum
);

	localparam int unsigned AW   = $clog2(MAX_ELEMENTS);
	localparam int unsigned PW0  = $clog2(MAX_ELEMENTS + 1);
	// positions carry one spare bit: the update chain may step past the top
	localparam int unsigned CW   = ((IDX_W > PW0) ? IDX_W : PW0) + 1;

	localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);
	localparam logic [AW-1:0] LAST_A = AW'(MAX_ELEMENTS - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ELEM  = 3'd2;
	localparam logic [2:0] S_URD   = 3'd3;
	localparam logic [2:0] S_UWR   = 3'd4;
	localparam logic [2:0] S_QRY   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] lft_q;
	sum_t          val_q;
	sum_t          delta_q;
	sum_t          acc_q;
	logic          phase_q;
	logic          pend_q;
	logic          pend_sub_q;
	logic          lev_q;
	logic          result_valid_q;
	sum_t          range_sum_q;

	sum_t tree_mem [MAX_ELEMENTS];
	sum_t elem_mem [MAX_ELEMENTS];
	sum_t tree_rd_q;
	sum_t elem_rd_q;

	logic          accept;
	logic [CW-1:0] idx_c;
	logic          idx_ok;
	sum_t          val_ext;
	sum_t          val_rule;
	logic [CW-1:0] l_sat;
	logic [CW-1:0] r_ext;
	logic [CW-1:0] r_sat;
	logic [CW-1:0] low_bit;
	logic [CW-1:0] pos_m1;
	logic [CW-1:0] idx_m1;
	sum_t          addend;

	logic          tree_re;
	logic          tree_we;
	logic [AW-1:0] tree_waddr;
	sum_t          tree_wdata;
	logic          elem_re;
	logic          elem_we;
	logic [AW-1:0] elem_waddr;
	sum_t          elem_wdata;

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid & item_ready;
	assign result_valid = result_valid_q;
	assign range_sum    = range_sum_q;

	assign idx_c    = CW'(index);
	assign idx_ok   = (idx_c != '0) && (idx_c <= MAX_C);
	assign idx_m1   = idx_c - CW'(1);
	assign val_ext  = {{(SUM_W - VAL_W){value[VAL_W-1]}}, value};
	// even positions are kept negated
	assign val_rule = index[0] ? val_ext : (sum_t'(0) - val_ext);

	assign l_sat = (left_end == '0) ? CW'(1) : CW'(left_end);
	assign r_ext = CW'(right_end);
	assign r_sat = (r_ext > MAX_C) ? MAX_C : r_ext;

	assign low_bit = pos_q & (~pos_q + CW'(1));
	assign pos_m1  = pos_q - CW'(1);
	assign addend  = tree_rd_q ^ {SUM_W{pend_sub_q}};

	always_comb begin
		tree_re    = 1'b0;
		tree_we    = 1'b0;
		tree_waddr = pos_m1[AW-1:0];
		tree_wdata = tree_rd_q + delta_q;
		elem_re    = accept && (operation == OP_SET) && idx_ok;
		elem_we    = 1'b0;
		elem_waddr = pos_m1[AW-1:0];
		elem_wdata = val_q;
		case (state_q)
			S_CLEAR: begin
				tree_we    = 1'b1;
				tree_waddr = clr_q;
				tree_wdata = '0;
				elem_we    = 1'b1;
				elem_waddr = clr_q;
				elem_wdata = '0;
			end
			S_ELEM:  elem_we = 1'b1;
			S_URD:   tree_re = (pos_q <= MAX_C);
			S_UWR:   tree_we = 1'b1;
			S_QRY:   tree_re = (pos_q != '0);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tree_we) begin
			tree_mem[tree_waddr] <= tree_wdata;
		end
		if (tree_re) begin
			tree_rd_q <= tree_mem[pos_m1[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (elem_we) begin
			elem_mem[elem_waddr] <= elem_wdata;
		end
		if (elem_re) begin
			elem_rd_q <= elem_mem[idx_m1[AW-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q      <= val_rule;
					pos_q      <= (operation == OP_SET) ? idx_c : r_sat;
					lft_q      <= l_sat;
					lev_q      <= ~l_sat[0];
					acc_q      <= '0;
					phase_q    <= 1'b0;
					pend_q     <= 1'b0;
					pend_sub_q <= 1'b0;
				end
			end
			S_ELEM: delta_q <= val_q - elem_rd_q;
			S_UWR:  pos_q   <= pos_q + low_bit;
			S_QRY: begin
				if (pend_q) begin
					acc_q <= acc_q + addend + sum_t'(pend_sub_q);
				end
				if (pos_q != '0) begin
					pend_q     <= 1'b1;
					pend_sub_q <= phase_q;
					pos_q      <= pos_q - low_bit;
				end else if (!phase_q) begin
					phase_q <= 1'b1;
					pend_q  <= 1'b0;
					pos_q   <= lft_q - CW'(1);
				end else begin
					pend_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_A) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (operation == OP_SET) begin
							if (idx_ok) begin
								state_q <= S_ELEM;
							end
						end else if (r_sat < l_sat) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_QRY;
						end
					end
				end
				S_ELEM: state_q <= S_URD;
				S_URD:  state_q <= (pos_q <= MAX_C) ? S_UWR : S_IDLE;
				S_UWR:  state_q <= S_URD;
				S_QRY: begin
					if (pos_q == '0 && phase_q && !pend_q) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// negate the prefix difference when the range opens on an even position
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!result_valid_q || result_ready)) begin
			range_sum_q <= lev_q ? (sum_t'(0) - acc_q) : acc_q;
		end
	end

`ifndef SYNTHESIS
	a_qry_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QRY && pos_q != '0) |-> (pos_q <= MAX_C))
		else $error("query walk address beyond the tree");

	a_upd_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UWR) |-> (pos_q != '0 && pos_q <= MAX_C))
		else $error("update write outside the tree");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_OUT))
		else $error("result loaded outside the output state");

	a_no_item_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |=> !(state_q == S_ELEM || state_q == S_QRY))
		else $error("item started during the clearing sweep");
`endif

endmodule
